// ===== hdl/smx_pkg.sv =====
// Shared types and constants of the softmax vector unit.
package smx_pkg;

    localparam int SMX_MAX_ITEMS = 16;

    localparam int SCORE_W = 16;
    localparam int PROB_W  = 16;
    localparam int POS_W   = 4;
    localparam int EXP_W   = 17;
    localparam int SUM_W   = 21;
    localparam int Q30_W   = 31;
    localparam int ACC_W   = 32;
    localparam int ARG_W   = 9;
    localparam int TERM_IDX_W = 5;

    localparam int EXP_TERMS = 20;
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;
    localparam int DIV_REM_W = SUM_W;

    localparam logic [ARG_W-1:0]   E1_ARG     = 9'd256;
    localparam logic signed [16:0] EXP_CUTOFF = 17'sd4096;
    localparam logic [Q30_W-1:0]   ONE_Q30    = 31'h4000_0000;
    localparam logic [61:0]        HALF_Q30   = 62'h2000_0000;
    localparam logic [31:0]        HALF_Q14   = 32'h0000_2000;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;
    localparam logic [SUM_W-1:0]   SUM_LIMIT  = 21'h1F_FFFF;
    localparam logic [PROB_W-1:0]  PROB_MAX   = 16'hFFFF;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SER_MUL,
        S_SER_DIV,
        S_SER_ACC,
        S_SER_END,
        S_RD,
        S_RDWAIT,
        S_EMUL,
        S_ERND,
        S_EXP_WR,
        S_DRD,
        S_DLD,
        S_DDIV,
        S_OUT
    } t_state;

endpackage

// ===== hdl/smx_ram.sv =====
// Generic single-port-write, registered-read RAM.
module smx_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/softmax_vector_unit.sv =====
// Top level of the softmax vector unit: loader, sequencer and shared arithmetic.
//
// Input channel (i_in_valid / o_in_stall) takes one signed Q8.8 score per
// transaction. A vector ends on the transaction with i_is_final set, or on
// the one that fills MAX_ITEMS entries. The block then stalls its input and
// returns one output transaction per element (o_out_valid / i_out_stall), in
// load order, carrying an unsigned Q0.16 probability, the element position
// and an end-of-run flag on the final element.
// Each exponential is a 20-term series; every term needs one pass of the
// shared restoring divider, and each whole unit of distance from the
// maximum adds a multiply and a rounding by exp(-1). The constant exp(-1)
// is built by the same series once after reset, before the first vector's
// first element. Each probability then takes a RAM read, an operand load
// and 33 divider steps before it is offered.
// Loading runs at one score per cycle.
// A stall on the output holds the offered result and the sequencer waits.
// Reset (synchronous, active low) empties the vector and returns to loading;
// the scratch memory needs no clearing.
module softmax_vector_unit #(
    parameter int MAX_ITEMS = smx_pkg::SMX_MAX_ITEMS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [smx_pkg::SCORE_W-1:0] i_score,
    input  logic                              i_is_final,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [smx_pkg::PROB_W-1:0]        o_probability,
    output logic [smx_pkg::POS_W-1:0]         o_position,
    output logic                              o_end_of_run
);

    import smx_pkg::*;

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    t_state r_state, n_state;

    logic [CNT_W-1:0]          r_count, n_count;
    logic signed [SCORE_W-1:0] r_max, n_max;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [Q30_W-1:0]          r_e1, n_e1;
    logic                      r_e1_ok, n_e1_ok;
    logic [ARG_W-1:0]          r_t, n_t;
    logic [TERM_IDX_W-1:0]     r_k, n_k;
    logic [Q30_W-1:0]          r_term, n_term;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic [Q30_W-1:0]          r_r, n_r;
    logic [4:0]                r_apow, n_apow;
    logic [61:0]               r_prod, n_prod;
    logic [DIV_REM_W-1:0]      r_dv_rem, n_dv_rem;
    logic [DIV_STEPS-1:0]      r_dv_quo, n_dv_quo;
    logic [SUM_W-1:0]          r_dv_den, n_dv_den;
    logic [DIV_CNT_W-1:0]      r_dv_cnt, n_dv_cnt;
    logic [PROB_W-1:0]         r_prob, n_prob;
    logic                      r_end, n_end;

    // RAM ports; an entry holds the score until its exponential overwrites it.
    logic                      ram_wr_en;
    logic [IDX_W-1:0]          ram_wr_addr;
    logic [EXP_W-1:0]          ram_wr_data;
    logic [EXP_W-1:0]          ram_rd_data;

    logic                      in_acc;
    logic [CNT_W-1:0]          count_inc;
    logic                      vec_end;
    logic                      idx_last;
    logic [IDX_W:0]            idx_inc_ext;
    logic [IDX_W+POS_W-1:0]    pos_ext;

    logic [Q30_W-1:0]          mul_a, mul_b;
    logic [61:0]               mul_p;
    logic [61:0]               rnd_p;
    logic [31:0]               e_rnd;
    logic [EXP_W-1:0]          e_val;
    logic [SUM_W:0]            sum_wide;

    logic signed [16:0]        score_gap;
    logic [DIV_REM_W:0]        rem_sh;
    logic [DIV_REM_W+1:0]      rem_diff;
    logic                      rem_ge;
    logic [DIV_REM_W-1:0]      rem_nx;
    logic [DIV_STEPS-1:0]      quo_nx;
    logic [PROB_W-1:0]         prob_sat;
    logic [Q30_W-1:0]          term_q;

    smx_ram #(
        .WIDTH (EXP_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd_data)
    );

    assign in_acc      = i_in_valid && (r_state == S_LOAD);
    assign count_inc   = r_count + 1'b1;
    assign vec_end     = i_is_final || (count_inc == CNT_W'(MAX_ITEMS));
    assign idx_inc_ext = (IDX_W+1)'(r_idx) + (IDX_W+1)'(1);
    assign idx_last    = (idx_inc_ext == (IDX_W+1)'(r_count));

    // One multiplier, shared between the series terms and the powers of exp(-1).
    assign mul_a = (r_state == S_EMUL) ? r_r  : r_term;
    assign mul_b = (r_state == S_EMUL) ? r_e1 : Q30_W'(r_t);
    assign mul_p = mul_a * mul_b;

    assign rnd_p    = r_prod + HALF_Q30;
    assign e_rnd    = 32'(r_r) + HALF_Q14;
    assign e_val    = e_rnd[30:14];
    assign sum_wide = (SUM_W+1)'(r_sum) + (SUM_W+1)'(e_val);

    assign score_gap = 17'(r_max) - 17'($signed(ram_rd_data[SCORE_W-1:0]));

    // Restoring divider step. A zero divisor gives an all-ones quotient,
    // which saturates like a quotient of one.
    assign rem_sh   = {r_dv_rem, r_dv_quo[DIV_STEPS-1]};
    assign rem_diff = {1'b0, rem_sh} - (DIV_REM_W+2)'(r_dv_den);
    assign rem_ge   = !rem_diff[DIV_REM_W+1];
    assign rem_nx   = rem_ge ? rem_diff[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
    assign quo_nx   = {r_dv_quo[DIV_STEPS-2:0], rem_ge};
    assign prob_sat = (|quo_nx[DIV_STEPS-1:PROB_W]) ? PROB_MAX : quo_nx[PROB_W-1:0];
    assign term_q   = r_dv_quo[Q30_W-1:0];

    assign pos_ext = (IDX_W+POS_W)'(r_idx);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && vec_end) begin
                    n_state = r_e1_ok ? S_RD : S_SER_MUL;
                end
            end
            S_SER_MUL: n_state = S_SER_DIV;
            S_SER_DIV: begin
                if (r_dv_cnt == DIV_CNT_W'(1)) begin
                    n_state = S_SER_ACC;
                end
            end
            S_SER_ACC: begin
                n_state = (r_k == TERM_IDX_W'(EXP_TERMS)) ? S_SER_END : S_SER_MUL;
            end
            S_SER_END: begin
                if (!r_e1_ok) begin
                    n_state = S_RD;
                end else if (r_apow == 5'd0) begin
                    n_state = S_EXP_WR;
                end else begin
                    n_state = S_EMUL;
                end
            end
            S_RD:     n_state = S_RDWAIT;
            S_RDWAIT: n_state = (score_gap > EXP_CUTOFF) ? S_EXP_WR : S_SER_MUL;
            S_EMUL:   n_state = S_ERND;
            S_ERND:   n_state = (r_apow == 5'd1) ? S_EXP_WR : S_EMUL;
            S_EXP_WR: n_state = idx_last ? S_DRD : S_RD;
            S_DRD:    n_state = S_DLD;
            S_DLD:    n_state = S_DDIV;
            S_DDIV: begin
                if (r_dv_cnt == DIV_CNT_W'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = r_end ? S_LOAD : S_DRD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_count  = r_count;
        n_max    = r_max;
        n_sum    = r_sum;
        n_idx    = r_idx;
        n_e1     = r_e1;
        n_e1_ok  = r_e1_ok;
        n_t      = r_t;
        n_k      = r_k;
        n_term   = r_term;
        n_acc    = r_acc;
        n_r      = r_r;
        n_apow   = r_apow;
        n_prod   = r_prod;
        n_dv_rem = r_dv_rem;
        n_dv_quo = r_dv_quo;
        n_dv_den = r_dv_den;
        n_dv_cnt = r_dv_cnt;
        n_prob   = r_prob;
        n_end    = r_end;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_idx;
        ram_wr_data = e_val;

        o_in_stall    = (r_state != S_LOAD);
        o_out_valid   = (r_state == S_OUT);
        o_probability = r_prob;
        o_position    = pos_ext[POS_W-1:0];
        o_end_of_run  = r_end;

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = r_count[IDX_W-1:0];
                    ram_wr_data = EXP_W'(unsigned'(i_score));
                    n_count     = count_inc;
                    if (i_score > r_max) begin
                        n_max = i_score;
                    end
                    n_idx  = '0;
                    n_sum  = '0;
                    // exp(-1) for the powers, built once after reset.
                    n_t    = E1_ARG;
                    n_term = ONE_Q30;
                    n_acc  = ACC_W'(ONE_Q30);
                    n_k    = TERM_IDX_W'(1);
                end
            end
            S_SER_MUL: begin
                // floor(x / (256k)) equals floor(floor(x / 256) / k).
                n_dv_quo = DIV_STEPS'(mul_p[38:8]);
                n_dv_den = SUM_W'(r_k);
                n_dv_rem = '0;
                n_dv_cnt = DIV_CNT_W'(DIV_STEPS);
            end
            S_SER_DIV, S_DDIV: begin
                n_dv_rem = rem_nx;
                n_dv_quo = quo_nx;
                n_dv_cnt = r_dv_cnt - 1'b1;
                if (r_state == S_DDIV && r_dv_cnt == DIV_CNT_W'(1)) begin
                    n_prob = prob_sat;
                    n_end  = idx_last;
                end
            end
            S_SER_ACC: begin
                n_term = term_q;
                if (r_k[0]) begin
                    n_acc = r_acc - $signed({1'b0, term_q});
                end else begin
                    n_acc = r_acc + $signed({1'b0, term_q});
                end
                n_k = r_k + 1'b1;
            end
            S_SER_END: begin
                if (!r_e1_ok) begin
                    n_e1    = r_acc[Q30_W-1:0];
                    n_e1_ok = 1'b1;
                end else begin
                    n_r = r_acc[Q30_W-1:0];
                end
            end
            S_RDWAIT: begin
                if (score_gap > EXP_CUTOFF) begin
                    n_r    = '0;
                    n_apow = '0;
                end else begin
                    n_t    = {1'b0, score_gap[7:0]};
                    n_apow = score_gap[12:8];
                    n_term = ONE_Q30;
                    n_acc  = ACC_W'(ONE_Q30);
                    n_k    = TERM_IDX_W'(1);
                end
            end
            S_EMUL: begin
                n_prod = mul_p;
            end
            S_ERND: begin
                n_r    = rnd_p[60:30];
                n_apow = r_apow - 1'b1;
            end
            S_EXP_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx;
                ram_wr_data = e_val;
                n_sum       = sum_wide[SUM_W] ? SUM_LIMIT : sum_wide[SUM_W-1:0];
                n_idx       = idx_last ? '0 : idx_inc_ext[IDX_W-1:0];
            end
            S_DLD: begin
                n_dv_quo = {ram_rd_data, {PROB_W{1'b0}}};
                n_dv_den = r_sum;
                n_dv_rem = '0;
                n_dv_cnt = DIV_CNT_W'(DIV_STEPS);
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_end) begin
                        n_count = '0;
                        n_max   = SCORE_MIN;
                        n_sum   = '0;
                        n_idx   = '0;
                    end else begin
                        n_idx = idx_inc_ext[IDX_W-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_max   <= SCORE_MIN;
            r_sum   <= '0;
            r_idx   <= '0;
            r_e1_ok <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_max   <= n_max;
            r_sum   <= n_sum;
            r_idx   <= n_idx;
            r_e1_ok <= n_e1_ok;
            r_end   <= n_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1     <= n_e1;
        r_t      <= n_t;
        r_k      <= n_k;
        r_term   <= n_term;
        r_acc    <= n_acc;
        r_r      <= n_r;
        r_apow   <= n_apow;
        r_prod   <= n_prod;
        r_dv_rem <= n_dv_rem;
        r_dv_quo <= n_dv_quo;
        r_dv_den <= n_dv_den;
        r_dv_cnt <= n_dv_cnt;
        r_prob   <= n_prob;
    end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the softmax vector unit, with its own softmax predictor.
`timescale 1ns / 100ps

module tb;

    localparam int SCORE_BITS     = smx_pkg::SCORE_W;
    localparam int PROB_BITS      = smx_pkg::PROB_W;
    localparam int POS_BITS       = smx_pkg::POS_W;
    localparam int VEC_DEPTH      = smx_pkg::SMX_MAX_ITEMS;
    localparam int SERIES_TERMS   = 20;
    localparam int EXP_SPAN       = 4096;
    localparam longint unsigned Q30_ONE  = 64'd1 << 30;
    localparam longint unsigned Q30_HALF = 64'd1 << 29;
    localparam longint unsigned Q14_HALF = 64'd1 << 13;
    localparam int unsigned SUM_CEIL  = 32'h001F_FFFF;
    localparam longint unsigned PROB_CEIL = 64'd65535;
    localparam int ITEM_TARGET    = 410;
    localparam int MAX_WAIT       = 13;
    localparam int HOLD_OFF_CYCLES = 6000;
    localparam int SETTLE_CYCLES  = 1000;
    localparam int WATCHDOG_LIMIT = 100000;

    typedef logic signed [SCORE_BITS-1:0] score_t;
    typedef struct packed {
        logic [PROB_BITS-1:0] probability;
        logic [POS_BITS-1:0]  position;
        logic                 end_of_run;
    } prob_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    score_t                i_score = '0;
    logic                  i_is_final = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PROB_BITS-1:0]  o_probability;
    logic [POS_BITS-1:0]   o_position;
    logic                  o_end_of_run;

    // Predictor state for the vector being loaded.
    score_t       loaded_scores [VEC_DEPTH];
    int           loaded_n = 0;
    score_t       peak_score = {1'b1, {(SCORE_BITS-1){1'b0}}};
    prob_result_t pending_probs [$];

    int  scores_sent = 0;
    int  error_count = 0;
    int  idle_cycles = 0;
    int  out_wait = 0;
    int  hold_len = 0;
    logic out_hold = 1'b0;
    logic offering = 1'b0;
    logic send_gaps_on = 1'b1;
    logic recv_stalls_on = 1'b1;

    softmax_vector_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_score       (i_score),
        .i_is_final    (i_is_final),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_probability (o_probability),
        .o_position    (o_position),
        .o_end_of_run  (o_end_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // exp(-t/256) in Q1.30 by an alternating Taylor series, t in 0..256.
    function automatic longint unsigned series_q30(input int unsigned t);
        longint unsigned term;
        longint          acc;
        term = Q30_ONE;
        acc  = longint'(Q30_ONE);
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = (term * t) / (256 * k);
            if (k % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        return longint'(acc);
    endfunction

    // exp(-score_gap/256) as unsigned Q1.16; whole units are applied as repeated exp(-1).
    function automatic int unsigned exp_weight(input int score_gap);
        longint unsigned r;
        longint unsigned e1;
        if (score_gap > EXP_SPAN) return 0;
        r  = series_q30(score_gap % 256);
        e1 = series_q30(256);
        for (int a = 0; a < score_gap / 256; a++) r = (r * e1 + Q30_HALF) >> 30;
        return int'((r + Q14_HALF) >> 14);
    endfunction

    task automatic send_score(input score_t score, input logic is_final);
        int              gap;
        int unsigned     weights [VEC_DEPTH];
        int unsigned     total;
        longint unsigned quot;
        prob_result_t    res;
        gap = send_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            if (offering) i_in_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_score    <= score;
        i_is_final <= is_final;
        offering = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        scores_sent++;

        loaded_scores[loaded_n] = score;
        loaded_n++;
        if (score > peak_score) peak_score = score;
        if (is_final || loaded_n == VEC_DEPTH) begin
            total = 0;
            for (int i = 0; i < loaded_n; i++) begin
                weights[i] = exp_weight(int'(peak_score) - int'(loaded_scores[i]));
                total += weights[i];
                if (total > SUM_CEIL) total = SUM_CEIL;
            end
            for (int i = 0; i < loaded_n; i++) begin
                quot = (total == 0) ? PROB_CEIL
                                    : (longint'(weights[i]) << 16) / total;
                if (quot > PROB_CEIL) quot = PROB_CEIL;
                res.probability = quot[PROB_BITS-1:0];
                res.position    = POS_BITS'(i);
                res.end_of_run  = (i == loaded_n - 1);
                pending_probs.push_back(res);
            end
            loaded_n   = 0;
            peak_score = {1'b1, {(SCORE_BITS-1){1'b0}}};
        end
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic wait_for_drain();
        if (offering) i_in_valid <= 1'b0;
        offering = 1'b0;
        while (pending_probs.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extreme_scores();
        // The winner saturates to 1.0 and the far loser gets exactly zero.
        send_score(16'sh7FFF, 1'b0);
        send_score(16'sh8000, 1'b1);
        // Two equal minimum scores share the probability evenly.
        send_score(16'sh8000, 1'b0);
        send_score(16'sh8000, 1'b1);
    endtask

    task automatic test_single_element();
        send_score(16'sh0000, 1'b1);
        send_score(16'sh5A5A, 1'b1);
    endtask

    task automatic test_exp_cutoff();
        // Distances from the maximum: 0, exactly the cut-off, one past it,
        // the top of a fractional unit and the first whole unit.
        send_score(16'sh0100, 1'b0);
        send_score(-16'sd3840, 1'b0);
        send_score(-16'sd3841, 1'b0);
        send_score(16'sh0001, 1'b0);
        send_score(16'sh0000, 1'b1);
    endtask

    task automatic test_buffer_full();
        score_t base;
        base = SCORE_BITS'($urandom);
        // No final marker: the sixteenth transaction must close the vector.
        for (int k = 0; k < VEC_DEPTH; k++)
            send_score(base + SCORE_BITS'($urandom_range(0, 1023)), 1'b0);
    endtask

    task automatic test_output_hold_off();
        score_t base;
        wait_for_drain();
        send_gaps_on = 1'b0;
        hold_len = HOLD_OFF_CYCLES;
        // The second vector is offered while the first one is still held at
        // the output, so the input has to stall.
        for (int v = 0; v < 2; v++) begin
            base = SCORE_BITS'($urandom);
            for (int k = 0; k < 3; k++)
                send_score(base + SCORE_BITS'($urandom_range(0, 255)), k == 2);
        end
        send_gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        int len;
        for (int v = 0; v < 3; v++) begin
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
                send_score(SCORE_BITS'($urandom), k == len - 1);
            wait_for_drain();
        end
    endtask

    task automatic test_random_vectors();
        int     len;
        int     pick;
        int     spread;
        logic   full_range;
        logic   end_flag;
        score_t base;
        score_t score;
        while (scores_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) len = $urandom_range(1, 6);
            else if (pick < 92) len = $urandom_range(7, VEC_DEPTH - 1);
            else len = VEC_DEPTH;
            end_flag = (len < VEC_DEPTH) ? 1'b1 : 1'($urandom_range(0, 1));
            full_range = ($urandom_range(0, 3) == 0);
            base = SCORE_BITS'($urandom);
            case ($urandom_range(0, 3))
                0: spread = 15;
                1: spread = 255;
                2: spread = 1023;
                default: spread = 4607;
            endcase
            send_gaps_on   = ($urandom_range(0, 3) != 0);
            recv_stalls_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < len; k++) begin
                score = full_range ? SCORE_BITS'($urandom)
                                   : base + SCORE_BITS'($urandom_range(0, spread));
                send_score(score, (k == len - 1) ? end_flag : 1'b0);
            end
            if ($urandom_range(0, 15) == 0) wait_for_drain();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extreme_scores();
        test_single_element();
        test_exp_cutoff();
        test_buffer_full();
        test_output_hold_off();
        test_drain_pause();
        test_random_vectors();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_probs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Long output hold-off, counted here so the sender can keep offering.
    initial begin
        forever begin
            wait (hold_len != 0);
            out_hold <= 1'b1;
            repeat (hold_len) @(posedge i_clk);
            out_hold <= 1'b0;
            hold_len = 0;
        end
    end

    // Output side: a fresh wait is drawn after each transaction and only
    // counts down while a result is actually on offer.
    always @(posedge i_clk) begin
        int next_wait;
        next_wait = out_wait;
        if (!i_rst_n) next_wait = 0;
        else if (o_out_valid && !i_out_stall)
            next_wait = recv_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
        else if (o_out_valid && next_wait != 0) next_wait--;
        out_wait    <= next_wait;
        i_out_stall <= (next_wait != 0) || out_hold;
    end

    always @(posedge i_clk) begin
        prob_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_probs.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("%0t: unexpected result prob=%0d pos=%0d end=%0b",
                             $realtime, o_probability, o_position, o_end_of_run);
            end else begin
                want = pending_probs.pop_front();
                if (o_probability !== want.probability || o_position !== want.position
                        || o_end_of_run !== want.end_of_run) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"%0t: mismatch expected prob=%0d pos=%0d end=%0b,",
                                  " got prob=%0d pos=%0d end=%0b"},
                                 $realtime, want.probability, want.position,
                                 want.end_of_run, o_probability, o_position,
                                 o_end_of_run);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
